### hdl/ideq_pkg.sv
// ----------------------------------------------------------------------------
// ideq_pkg
// Shared types and constants for the integer deque with statistics.
// ----------------------------------------------------------------------------
package ideq_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic               ok;
        logic [6:0]         count;
        logic signed [31:0] first_value;
        logic signed [31:0] last_value;
        logic signed [31:0] total;
        logic signed [31:0] largest;
        logic signed [31:0] smallest;
        logic signed [39:0] mean;
    } t_out;

    // Classified request passed from the front part to the back part.
    typedef struct packed {
        logic          ok;
        logic          wr;
        logic [AW-1:0] wr_addr;
        logic [31:0]   wr_data;
        logic [AW-1:0] head;
        logic [CW-1:0] count;
    } t_cmd;

endpackage

### hdl/ideq_ram.sv
// ----------------------------------------------------------------------------
// ideq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ideq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ideq_front.sv
// ----------------------------------------------------------------------------
// ideq_front
// Accepts requests, tracks head and count, and issues classified commands.
// ----------------------------------------------------------------------------
module ideq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  ideq_pkg::t_in i_data,
    output logic          o_cmd_valid,
    output ideq_pkg::t_cmd o_cmd,
    input  logic          i_cmd_take
);
    import ideq_pkg::*;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_valid;
    t_cmd          r_cmd, n_cmd;
    logic          not_full, not_empty;
    logic [AW-1:0] tail;

    assign not_full  = (r_count < CW'(DEPTH));
    assign not_empty = (r_count != '0);
    assign tail      = r_head + r_count[AW-1:0];
    assign o_full    = r_valid && !i_cmd_take;

    always_comb begin
        n_head        = r_head;
        n_count       = r_count;
        n_cmd.ok      = 1'b0;
        n_cmd.wr      = 1'b0;
        n_cmd.wr_addr = tail;
        n_cmd.wr_data = i_data.value;
        case (i_data.operation)
            OP_PUSH_FRONT: begin
                if (not_full) begin
                    n_head        = r_head - 1'b1;
                    n_count       = r_count + 1'b1;
                    n_cmd.ok      = 1'b1;
                    n_cmd.wr      = 1'b1;
                    n_cmd.wr_addr = r_head - 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (not_full) begin
                    n_count  = r_count + 1'b1;
                    n_cmd.ok = 1'b1;
                    n_cmd.wr = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (not_empty) begin
                    n_head   = r_head + 1'b1;
                    n_count  = r_count - 1'b1;
                    n_cmd.ok = 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (not_empty) begin
                    n_count  = r_count - 1'b1;
                    n_cmd.ok = 1'b1;
                end
            end
            OP_QUERY: n_cmd.ok = 1'b1;
            default:  n_cmd.ok = 1'b0;
        endcase
        n_cmd.head  = n_head;
        n_cmd.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_push && !o_full) || (r_valid && !i_cmd_take);
            if (i_push && !o_full) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_cmd   <= n_cmd;
            end
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("count above depth");
    a_full_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> !o_full) else $error("full with empty slot");
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && !n_cmd.ok) |=> $stable(r_count))
        else $error("rejected request changed count");

endmodule

### hdl/ideq_back.sv
// ----------------------------------------------------------------------------
// ideq_back
// Writes the store, walks all entries for sum, min and max, divides for the
// mean, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module ideq_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  ideq_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    output logic           o_empty,
    input  logic           i_pop,
    output ideq_pkg::t_out o_data
);
    import ideq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_DIV  = 5'b00100,
        S_DONE = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    t_state        r_state;
    t_cmd          r_cmd;
    logic [CW-1:0] r_rd_cnt;
    logic [CW-1:0] r_got;
    logic          r_rd_pend;
    logic [31:0]   r_sum, r_first, r_last;
    logic signed [31:0] r_max, r_min;
    logic [39:0]   r_rem, r_quo;
    logic [5:0]    r_bit;
    logic          r_neg;
    logic          r_out_valid;
    t_out          r_out;

    logic [AW-1:0] raddr;
    logic [31:0]   rdata;
    logic signed [31:0] rs;
    logic [40:0]   trial;
    logic [39:0]   rem_sh;
    logic          out_load;

    assign raddr = r_cmd.head + r_rd_cnt[AW-1:0];

    ideq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (o_cmd_take && i_cmd.wr),
        .i_waddr(i_cmd.wr_addr),
        .i_wdata(i_cmd.wr_data),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rs         = $signed(rdata);
    assign o_cmd_take = i_cmd_valid && (r_state == S_IDLE);
    assign rem_sh     = {r_rem[38:0], r_quo[39]};
    assign trial      = {1'b0, rem_sh} - {{(41-CW){1'b0}}, r_cmd.count};
    assign out_load   = (r_state == S_HOLD) && (!r_out_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_cmd     <= i_cmd;
                        r_rd_cnt  <= '0;
                        r_got     <= '0;
                        r_rd_pend <= 1'b0;
                        r_sum     <= '0;
                        r_state   <= S_WALK;
                    end
                end
                S_WALK: begin
                    r_rd_pend <= (r_rd_cnt < r_cmd.count);
                    if (r_rd_cnt < r_cmd.count) begin
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                    end
                    if (r_rd_pend) begin
                        r_sum <= r_sum + rdata;
                        if (r_got == '0) begin
                            r_first <= rdata;
                            r_max   <= rs;
                            r_min   <= rs;
                        end else begin
                            if (rs > r_max) r_max <= rs;
                            if (rs < r_min) r_min <= rs;
                        end
                        r_last <= rdata;
                        r_got  <= r_got + 1'b1;
                    end
                    if (!r_rd_pend && r_rd_cnt == r_cmd.count) begin
                        r_neg   <= r_sum[31];
                        r_rem   <= '0;
                        r_quo   <= {(r_sum[31] ? 32'(-r_sum) : r_sum), 8'd0};
                        r_bit   <= 6'd40;
                        r_state <= (r_cmd.count == '0) ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    if (!trial[40]) begin
                        r_rem <= trial[39:0];
                        r_quo <= {r_quo[38:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[38:0], 1'b0};
                    end
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == 6'd1) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (out_load) begin
                        r_out.ok    <= r_cmd.ok;
                        r_out.count <= 7'(r_cmd.count);
                        if (r_cmd.count == '0) begin
                            r_out.first_value <= -32'sd1;
                            r_out.last_value  <= -32'sd1;
                            r_out.total       <= '0;
                            r_out.largest     <= -32'sd1;
                            r_out.smallest    <= -32'sd1;
                            r_out.mean        <= '0;
                        end else begin
                            r_out.first_value <= r_first;
                            r_out.last_value  <= r_last;
                            r_out.total       <= r_sum;
                            r_out.largest     <= r_max;
                            r_out.smallest    <= r_min;
                            r_out.mean        <= r_neg ? -r_quo : r_quo;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty = !r_out_valid;
    assign o_data  = r_out;

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |=> r_state == S_WALK) else $error("take outside idle");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_rd_cnt <= r_cmd.count) else $error("walk overrun");
    a_div_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_bit != 6'd0) else $error("divider overrun");

endmodule

### hdl/integer_deque_with_statistics_top.sv
// ----------------------------------------------------------------------------
// integer_deque_with_statistics_top
// Bounded deque of signed 32-bit integers reporting count, ends, sum, min,
// max and mean after every request.
// ----------------------------------------------------------------------------
// Each request in the back part makes one store read per held entry for sum, min
// and max, then, unless the deque is empty, a 40-step restoring division for
// the mean. The front part takes the next request while the back part works.
module integer_deque_with_statistics_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  ideq_pkg::t_in  i_data,
    output logic           empty,
    input  logic           pop,
    output ideq_pkg::t_out o_data
);
    import ideq_pkg::*;

    logic cmd_valid, cmd_take;
    t_cmd cmd;

    ideq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_data(i_data), .o_cmd_valid(cmd_valid), .o_cmd(cmd),
        .i_cmd_take(cmd_take)
    );

    ideq_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_take(cmd_take), .o_empty(empty), .i_pop(pop), .o_data(o_data)
    );

endmodule
